// ===== hw/rtl/mnrt_pkg.sv =====
// shared types, codes and command structs for the note remap table
`default_nettype none

package mnrt_pkg;

    localparam int ENTRY_W = 24;

    // operation codes carried in the func field
    localparam logic [2:0] FUNC_REMAP     = 3'd0;
    localparam logic [2:0] FUNC_READ      = 3'd1;
    localparam logic [2:0] FUNC_OVERWRITE = 3'd2;
    localparam logic [2:0] FUNC_APPEND    = 3'd3;
    localparam logic [2:0] FUNC_INSERT    = 3'd4;
    localparam logic [2:0] FUNC_REMOVE    = 3'd5;
    localparam logic [2:0] FUNC_CLEAR     = 3'd6;

    // status codes of a result beat
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOMATCH = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [6:0] src_note;
        logic [4:0] src_chan;
        logic [6:0] dst_note;
        logic [4:0] dst_chan;
    } entry_t;

    typedef enum logic [2:0] {
        RES_HIT,
        RES_MISS,
        RES_READ,
        RES_OK,
        RES_BAD,
        RES_FULL
    } res_kind_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_IDX1,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_M1,
        RD_IDX
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT,
        WR_AT_IDX,
        WR_AT_CLAMP
    } wr_sel_t;

    typedef struct packed {
        logic      capture;
        ptr_op_t   ptr_op;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        cnt_op_t   cnt_op;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       idx_ok;
        logic       full;
        logic       hit;
        logic       ptr_lt_count;
        logic       ptr_gt_clamp;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mnrt_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module mnrt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mnrt_ctrl.sv =====
// controller state machine: sequences remap walks, shifts and result beats
`default_nettype none

module mnrt_ctrl
    import mnrt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output      logic  in_stall,
    output      logic  out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output      cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_REMAP,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM_SHIFT,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    logic      pend_reg, pend_next;
    res_kind_t res_reg, res_next;
    logic      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd.capture  = 1'b0;
        cmd.ptr_op   = PTR_HOLD;
        cmd.rd_en    = 1'b0;
        cmd.rd_sel   = RD_PTR;
        cmd.wr_en    = 1'b0;
        cmd.wr_sel   = WR_SHIFT;
        cmd.cnt_op   = CNT_HOLD;
        cmd.res_load = 1'b0;
        cmd.res_kind = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                pend_next  = 1'b0;
                state_next = S_FINISH;
                unique case (stat.func) inside
                    FUNC_REMAP:
                    begin
                        cmd.ptr_op = PTR_ZERO;
                        state_next = S_REMAP;
                    end
                    FUNC_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX;
                            res_next   = RES_READ;
                        end
                        else
                        begin
                            res_next = RES_BAD;
                        end
                    end
                    FUNC_OVERWRITE:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_AT_IDX;
                            res_next   = RES_OK;
                        end
                        else
                        begin
                            res_next = RES_BAD;
                        end
                    end
                    FUNC_APPEND, FUNC_INSERT:
                    begin
                        if (stat.full)
                        begin
                            res_next = RES_FULL;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_COUNT;
                            state_next = S_INS_SHIFT;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.ptr_op = PTR_IDX1;
                            state_next = S_REM_SHIFT;
                        end
                        else
                        begin
                            res_next = RES_BAD;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLEAR;
                        res_next   = RES_OK;
                    end
                    default:
                    begin
                        res_next = RES_BAD;
                    end
                endcase
            end
            S_REMAP:
            begin
                // one entry read per cycle, compared the cycle after
                if (pend_reg && stat.hit)
                begin
                    res_next   = RES_HIT;
                    state_next = S_FINISH;
                end
                else if (stat.ptr_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR;
                    cmd.ptr_op = PTR_INC;
                    pend_next  = 1'b1;
                end
                else
                begin
                    res_next   = RES_MISS;
                    state_next = S_FINISH;
                end
            end
            S_INS_SHIFT:
            begin
                // read entry ptr-1 and write it one place up next cycle
                cmd.wr_en  = pend_reg;
                cmd.wr_sel = WR_SHIFT;
                if (stat.ptr_gt_clamp)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_M1;
                    cmd.ptr_op = PTR_DEC;
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_AT_CLAMP;
                cmd.cnt_op = CNT_INC;
                res_next   = RES_OK;
                state_next = S_FINISH;
            end
            S_REM_SHIFT:
            begin
                cmd.wr_en  = pend_reg;
                cmd.wr_sel = WR_SHIFT;
                if (stat.ptr_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR;
                    cmd.ptr_op = PTR_INC;
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    cmd.cnt_op = CNT_DEC;
                    res_next   = RES_OK;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait here while the previous result beat is still held
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            res_reg       <= RES_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_one_item_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("second item accepted while one is in progress");

    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg
    ) else $error("stalled result beat dropped");

    a_load_only_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && out_stall)
    ) else $error("result loaded over a held beat");

endmodule

`default_nettype wire

// ===== hw/rtl/mnrt_datapath.sv =====
// datapath: request registers, entry count, walk pointer, table ram and result registers
`default_nettype none

module mnrt_datapath
    import mnrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [2:0] func,
    input  wire logic [6:0] index,
    input  wire logic [6:0] in_note,
    input  wire logic [4:0] in_channel,
    input  wire logic [6:0] entry_source_note,
    input  wire logic [4:0] entry_source_channel,
    input  wire logic [6:0] entry_target_note,
    input  wire logic [4:0] entry_target_channel,
    input  wire cmd_t       cmd,
    output      stat_t      stat,
    output      logic [1:0] status,
    output      logic [6:0] out_note,
    output      logic [4:0] out_channel,
    output      logic [6:0] out_source_note,
    output      logic [4:0] out_source_channel,
    output      logic [6:0] entry_count
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [2:0]    func_reg;
    logic [6:0]    idx_reg;
    logic [6:0]    note_reg;
    logic [4:0]    chan_reg;
    entry_t        entry_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] ptr_m1;
    logic [AW-1:0] wa_reg, wa_next;

    logic [1:0]    status_reg, status_next;
    logic [6:0]    out_note_reg, out_note_next;
    logic [4:0]    out_channel_reg, out_channel_next;
    logic [6:0]    out_source_note_reg, out_source_note_next;
    logic [4:0]    out_source_channel_reg, out_source_channel_next;
    logic [6:0]    entry_count_reg;

    logic [CW-1:0] clamp;
    logic          idx_ok;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;

    assign ptr_m1 = ptr_reg - 1'b1;
    assign idx_ok = CMPW'(idx_reg) < CMPW'(count_reg);
    // insert past the end lands at the end, append always does
    assign clamp  = (func_reg == FUNC_APPEND || !idx_ok) ? count_reg : CW'(idx_reg);

    assign stat.func         = func_reg;
    assign stat.idx_ok       = idx_ok;
    assign stat.full         = (count_reg == CW'(TABLE_DEPTH));
    assign stat.hit          = (rd_data.src_note == note_reg) &&
                               (rd_data.src_chan == 5'd0 || rd_data.src_chan == chan_reg);
    assign stat.ptr_lt_count = (ptr_reg < count_reg);
    assign stat.ptr_gt_clamp = (ptr_reg > clamp);

    always_comb
    begin
        ptr_next = ptr_reg;
        unique case (cmd.ptr_op)
            PTR_HOLD:  ptr_next = ptr_reg;
            PTR_ZERO:  ptr_next = '0;
            PTR_COUNT: ptr_next = count_reg;
            PTR_IDX1:  ptr_next = CW'(idx_reg) + 1'b1;
            PTR_INC:   ptr_next = ptr_reg + 1'b1;
            PTR_DEC:   ptr_next = ptr_m1;
            default:   ptr_next = ptr_reg;
        endcase

        count_next = count_reg;
        unique case (cmd.cnt_op)
            CNT_HOLD:  count_next = count_reg;
            CNT_INC:   count_next = count_reg + 1'b1;
            CNT_DEC:   count_next = count_reg - 1'b1;
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase

        rd_en   = cmd.rd_en;
        rd_addr = ptr_reg[AW-1:0];
        unique case (cmd.rd_sel)
            RD_PTR:    rd_addr = ptr_reg[AW-1:0];
            RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
            RD_IDX:    rd_addr = AW'(idx_reg);
            default:   rd_addr = ptr_reg[AW-1:0];
        endcase

        // shift destination: one up from the read when inserting, one down when removing
        wa_next = (cmd.rd_sel == RD_PTR_M1) ? ptr_reg[AW-1:0] : ptr_m1[AW-1:0];

        wr_en   = cmd.wr_en;
        wr_addr = wa_reg;
        wr_data = entry_reg;
        unique case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_addr = wa_reg;
                wr_data = rd_data;
            end
            WR_AT_IDX:   wr_addr = AW'(idx_reg);
            WR_AT_CLAMP: wr_addr = clamp[AW-1:0];
            default:     wr_addr = wa_reg;
        endcase
    end

    always_comb
    begin
        status_next             = STATUS_NOMATCH;
        out_note_next           = 7'd0;
        out_channel_next        = 5'd0;
        out_source_note_next    = 7'd0;
        out_source_channel_next = 5'd0;
        case (cmd.res_kind)
            RES_HIT:
            begin
                status_next      = STATUS_OK;
                out_note_next    = rd_data.dst_note;
                out_channel_next = (rd_data.dst_chan == 5'd0) ? chan_reg : rd_data.dst_chan;
            end
            RES_MISS:
            begin
                status_next      = STATUS_NOMATCH;
                out_note_next    = note_reg;
                out_channel_next = chan_reg;
            end
            RES_READ:
            begin
                status_next             = STATUS_OK;
                out_note_next           = rd_data.dst_note;
                out_channel_next        = rd_data.dst_chan;
                out_source_note_next    = rd_data.src_note;
                out_source_channel_next = rd_data.src_chan;
            end
            RES_OK:   status_next = STATUS_OK;
            RES_FULL: status_next = STATUS_FULL;
            default:  status_next = STATUS_NOMATCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        wa_reg  <= wa_next;
        if (cmd.capture)
        begin
            func_reg           <= func;
            idx_reg            <= index;
            note_reg           <= in_note;
            chan_reg           <= in_channel;
            entry_reg.src_note <= entry_source_note;
            entry_reg.src_chan <= entry_source_channel;
            entry_reg.dst_note <= entry_target_note;
            entry_reg.dst_chan <= entry_target_channel;
        end
        if (cmd.res_load)
        begin
            entry_count_reg        <= 7'(count_reg);
            status_reg             <= status_next;
            out_note_reg           <= out_note_next;
            out_channel_reg        <= out_channel_next;
            out_source_note_reg    <= out_source_note_next;
            out_source_channel_reg <= out_source_channel_next;
        end
    end

    mnrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status             = status_reg;
    assign out_note           = out_note_reg;
    assign out_channel        = out_channel_reg;
    assign out_source_note    = out_source_note_reg;
    assign out_source_channel = out_source_channel_reg;
    assign entry_count        = entry_count_reg;

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)
    ) else $error("entry count above table depth");

    a_walk_reads_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.rd_sel == RD_PTR) |-> (ptr_reg < count_reg)
    ) else $error("walk reads past the last valid entry");

    a_put_needs_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == WR_AT_CLAMP) |-> (count_reg < CW'(TABLE_DEPTH))
    ) else $error("insert write on a full table");

endmodule

`default_nettype wire

// ===== hw/rtl/midi_note_remap_table.sv =====
// top level of the midi note remap table
// Input channel: in_valid/in_stall carry one request beat (func, index, note,
// channel and an entry). Output channel: out_valid/out_stall carry one result
// beat per request (status, notes, channels, entry count after the request).
// One request is in work at a time; in_stall is high from acceptance until
// its result is loaded into the output register. The output register frees
// the input side, so the next request is taken while a result still waits.
// Work per request, N = valid entries: read, overwrite, clear, bad index and
// full table touch at most one entry; remap walks the entries in order up to
// N, one table read per cycle, until the first hit; insert/append at position
// p shifts the N - p entries at and above p one place up, remove at position p
// shifts the entries above p one place down. The next request is taken in the
// cycle out_valid rises. The table ram has a single read port and a single
// write port: one entry is moved or compared per cycle.
// A stalled result beat holds; a finished request then waits until the
// beat is taken. Reset empties the table (count to zero); the ram content
// is not cleared, since only entries below the count are ever read.
`default_nettype none

module midi_note_remap_table
    import mnrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [2:0] func,
    input  wire logic [6:0] index,
    input  wire logic [6:0] in_note,
    input  wire logic [4:0] in_channel,
    input  wire logic [6:0] entry_source_note,
    input  wire logic [4:0] entry_source_channel,
    input  wire logic [6:0] entry_target_note,
    input  wire logic [4:0] entry_target_channel,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [1:0] status,
    output      logic [6:0] out_note,
    output      logic [4:0] out_channel,
    output      logic [6:0] out_source_note,
    output      logic [4:0] out_source_channel,
    output      logic [6:0] entry_count
);

    cmd_t  cmd;
    stat_t stat;

    mnrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mnrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .func                 (func),
        .index                (index),
        .in_note              (in_note),
        .in_channel           (in_channel),
        .entry_source_note    (entry_source_note),
        .entry_source_channel (entry_source_channel),
        .entry_target_note    (entry_target_note),
        .entry_target_channel (entry_target_channel),
        .cmd                  (cmd),
        .stat                 (stat),
        .status               (status),
        .out_note             (out_note),
        .out_channel          (out_channel),
        .out_source_note      (out_source_note),
        .out_source_channel   (out_source_channel),
        .entry_count          (entry_count)
    );

endmodule

`default_nettype wire

// ===== dv/midi_note_remap_table_tb.sv =====
// testbench for the midi note remap table: directed and random requests checked against a predictor
module midi_note_remap_table_tb
    import mnrt_pkg::*;
();

    localparam int DEPTH = 64;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_REQUESTS = 900;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] note;
        logic [4:0] chan;
        logic [6:0] snote;
        logic [4:0] schan;
        logic [6:0] count;
    } remap_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] func;
    logic [6:0] index;
    logic [6:0] in_note;
    logic [4:0] in_channel;
    logic [6:0] entry_source_note;
    logic [4:0] entry_source_channel;
    logic [6:0] entry_target_note;
    logic [4:0] entry_target_channel;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic [6:0] out_note;
    logic [4:0] out_channel;
    logic [6:0] out_source_note;
    logic [4:0] out_source_channel;
    logic [6:0] entry_count;

    entry_t        shadow_table [DEPTH];
    int            shadow_count;
    remap_result_t expected_results [$];
    int unsigned   error_count;
    int unsigned   results_checked;
    int unsigned   burst_left;
    int unsigned   cycle_count;
    int unsigned   requests_by_func [8];
    int unsigned   remap_hits;
    int unsigned   remap_misses;
    int unsigned   full_rejects;
    int unsigned   bad_index_hits;

    midi_note_remap_table uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .func                 (func),
        .index                (index),
        .in_note              (in_note),
        .in_channel           (in_channel),
        .entry_source_note    (entry_source_note),
        .entry_source_channel (entry_source_channel),
        .entry_target_note    (entry_target_note),
        .entry_target_channel (entry_target_channel),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .status               (status),
        .out_note             (out_note),
        .out_channel          (out_channel),
        .out_source_note      (out_source_note),
        .out_source_channel   (out_source_channel),
        .entry_count          (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // applies one request to the shadow table and returns the result beat it should produce
    function automatic remap_result_t apply_remap_request(input logic [2:0] f,
            input logic [6:0] idx, input logic [6:0] note, input logic [4:0] chan,
            input entry_t ent);
        remap_result_t r;
        bit            found;
        int            pos;
        r = '0;
        r.status = STATUS_NOMATCH;
        found = 1'b0;
        case (f)
            FUNC_REMAP:
            begin
                r.note = note;
                r.chan = chan;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!found && shadow_table[i].src_note == note &&
                        (shadow_table[i].src_chan == 5'd0 || shadow_table[i].src_chan == chan))
                    begin
                        found = 1'b1;
                        r.note = shadow_table[i].dst_note;
                        r.chan = (shadow_table[i].dst_chan == 5'd0) ? chan
                                                                   : shadow_table[i].dst_chan;
                        r.status = STATUS_OK;
                    end
                end
                if (found)
                    remap_hits++;
                else
                    remap_misses++;
            end
            FUNC_READ:
            begin
                if (idx < shadow_count)
                begin
                    r.note = shadow_table[idx].dst_note;
                    r.chan = shadow_table[idx].dst_chan;
                    r.snote = shadow_table[idx].src_note;
                    r.schan = shadow_table[idx].src_chan;
                    r.status = STATUS_OK;
                end
                else
                    bad_index_hits++;
            end
            FUNC_OVERWRITE:
            begin
                if (idx < shadow_count)
                begin
                    shadow_table[idx] = ent;
                    r.status = STATUS_OK;
                end
                else
                    bad_index_hits++;
            end
            FUNC_APPEND:
            begin
                if (shadow_count < DEPTH)
                begin
                    shadow_table[shadow_count] = ent;
                    shadow_count++;
                    r.status = STATUS_OK;
                end
                else
                begin
                    r.status = STATUS_FULL;
                    full_rejects++;
                end
            end
            FUNC_INSERT:
            begin
                if (shadow_count < DEPTH)
                begin
                    pos = (idx > shadow_count) ? shadow_count : idx;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_table[i] = shadow_table[i - 1];
                    shadow_table[pos] = ent;
                    shadow_count++;
                    r.status = STATUS_OK;
                end
                else
                begin
                    r.status = STATUS_FULL;
                    full_rejects++;
                end
            end
            FUNC_REMOVE:
            begin
                if (idx < shadow_count)
                begin
                    for (int i = idx; i + 1 < shadow_count; i++)
                        shadow_table[i] = shadow_table[i + 1];
                    shadow_count--;
                    r.status = STATUS_OK;
                end
                else
                    bad_index_hits++;
            end
            FUNC_CLEAR:
            begin
                shadow_count = 0;
                r.status = STATUS_OK;
            end
            default:
                r.status = STATUS_NOMATCH;
        endcase
        r.count = shadow_count[6:0];
        return r;
    endfunction

    function automatic entry_t make_entry(input logic [6:0] sn, input logic [4:0] sc,
            input logic [6:0] tn, input logic [4:0] tc);
        entry_t e;
        e.src_note = sn;
        e.src_chan = sc;
        e.dst_note = tn;
        e.dst_chan = tc;
        return e;
    endfunction

    // notes cluster in a small range now and then so entries shadow each other
    function automatic entry_t random_entry();
        entry_t e;
        if ($urandom_range(0, 1) == 1)
            e.src_note = 7'($urandom_range(36, 51));
        else
            e.src_note = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0)
            e.src_chan = 5'd0;
        else
            e.src_chan = 5'($urandom_range(1, 16));
        e.dst_note = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0)
            e.dst_chan = 5'd0;
        else
            e.dst_chan = 5'($urandom_range(1, 16));
        return e;
    endfunction

    function automatic logic [6:0] absent_note();
        int  start;
        int  cand;
        bit  used;
        start = $urandom_range(0, 127);
        for (int n = 0; n < 128; n++)
        begin
            cand = (start + n) % 128;
            used = 1'b0;
            for (int i = 0; i < shadow_count; i++)
                if (shadow_table[i].src_note == cand)
                    used = 1'b1;
            if (!used)
                return cand[6:0];
        end
        return 7'd0;
    endfunction

    // drives one request beat, holds it until accepted, then records the expected result
    task automatic send_request(input logic [2:0] f, input logic [6:0] idx,
            input logic [6:0] note, input logic [4:0] chan, input entry_t ent);
        remap_result_t exp_r;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= f;
        index <= idx;
        in_note <= note;
        in_channel <= chan;
        entry_source_note <= ent.src_note;
        entry_source_channel <= ent.src_chan;
        entry_target_note <= ent.dst_note;
        entry_target_channel <= ent.dst_chan;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp_r = apply_remap_request(f, idx, note, chan, ent);
        expected_results = {expected_results, exp_r};
        requests_by_func[f]++;
    endtask

    task automatic check_result();
        remap_result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $error("result beat with no request outstanding");
            error_count++;
        end
        else
        begin
            exp_r = expected_results.pop_front();
            results_checked++;
            if (status !== exp_r.status)
            begin
                $error("status: expected %0d, actual %0d", exp_r.status, status);
                error_count++;
            end
            if (out_note !== exp_r.note)
            begin
                $error("out_note: expected %0d, actual %0d", exp_r.note, out_note);
                error_count++;
            end
            if (out_channel !== exp_r.chan)
            begin
                $error("out_channel: expected %0d, actual %0d", exp_r.chan, out_channel);
                error_count++;
            end
            if (out_source_note !== exp_r.snote)
            begin
                $error("out_source_note: expected %0d, actual %0d", exp_r.snote,
                       out_source_note);
                error_count++;
            end
            if (out_source_channel !== exp_r.schan)
            begin
                $error("out_source_channel: expected %0d, actual %0d", exp_r.schan,
                       out_source_channel);
                error_count++;
            end
            if (entry_count !== exp_r.count)
            begin
                $error("entry_count: expected %0d, actual %0d", exp_r.count, entry_count);
                error_count++;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
        end
    end

    // receiver backpressure: free-running, random, or long runs; the mode is picked anew for each phase
    initial
    begin
        int unsigned stall_mode;
        int unsigned phase_left;
        int unsigned run_left;
        logic        run_level;
        stall_mode = 0;
        phase_left = 0;
        run_left = 0;
        run_level = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                phase_left = 256;
            end
            phase_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_level = ~run_level;
                        run_left = $urandom_range(1, 16);
                    end
                    run_left--;
                    out_stall <= run_level;
                end
            endcase
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // requests that fail on an empty table, plus the unused selector and a clear
    task automatic test_empty_table();
        send_request(FUNC_REMAP, 7'd0, 7'd127, 5'd16, '0);
        send_request(FUNC_READ, 7'd0, 7'd0, 5'd0, '0);
        send_request(FUNC_OVERWRITE, 7'd0, 7'd0, 5'd0, make_entry(7'd1, 5'd1, 7'd2, 5'd2));
        send_request(FUNC_REMOVE, 7'd127, 7'd0, 5'd0, '0);
        send_request(FUNC_UNUSED, 7'd127, 7'd127, 5'd31, make_entry(7'd127, 5'd31, 7'd127,
                     5'd31));
        send_request(FUNC_CLEAR, 7'd0, 7'd0, 5'd0, '0);
    endtask

    // edits at both ends, clamped insert, wildcard and keep-channel matching, first match wins
    task automatic test_edit_and_match();
        send_request(FUNC_APPEND, 7'd0, 7'd0, 5'd0, make_entry(7'd0, 5'd0, 7'd127, 5'd0));
        send_request(FUNC_APPEND, 7'd0, 7'd0, 5'd0, make_entry(7'd60, 5'd5, 7'd72, 5'd16));
        send_request(FUNC_APPEND, 7'd0, 7'd0, 5'd0, make_entry(7'd60, 5'd0, 7'd61, 5'd1));
        send_request(FUNC_INSERT, 7'd127, 7'd0, 5'd0, make_entry(7'd127, 5'd16, 7'd0, 5'd3));
        send_request(FUNC_INSERT, 7'd0, 7'd0, 5'd0, make_entry(7'd10, 5'd1, 7'd20, 5'd2));
        send_request(FUNC_READ, 7'd0, 7'd0, 5'd0, '0);
        send_request(FUNC_READ, 7'd4, 7'd0, 5'd0, '0);
        send_request(FUNC_READ, 7'd5, 7'd0, 5'd0, '0);
        send_request(FUNC_REMAP, 7'd0, 7'd0, 5'd16, '0);
        send_request(FUNC_REMAP, 7'd0, 7'd60, 5'd5, '0);
        send_request(FUNC_REMAP, 7'd0, 7'd60, 5'd9, '0);
        send_request(FUNC_REMAP, 7'd0, 7'd127, 5'd16, '0);
        send_request(FUNC_REMAP, 7'd0, 7'd127, 5'd15, '0);
        send_request(FUNC_OVERWRITE, 7'd2, 7'd0, 5'd0, make_entry(7'd60, 5'd9, 7'd99, 5'd0));
        send_request(FUNC_REMAP, 7'd0, 7'd60, 5'd9, '0);
        send_request(FUNC_REMOVE, 7'd0, 7'd0, 5'd0, '0);
        send_request(FUNC_REMOVE, 7'd3, 7'd0, 5'd0, '0);
        send_request(FUNC_READ, 7'd1, 7'd0, 5'd0, '0);
        send_request(FUNC_OVERWRITE, 7'd3, 7'd0, 5'd0, make_entry(7'd1, 5'd1, 7'd1, 5'd1));
    endtask

    // fill to the top, bounce off it, then walk and shift the full depth
    task automatic test_full_table();
        entry_t     last;
        logic [4:0] chan;
        send_request(FUNC_CLEAR, 7'd0, 7'd0, 5'd0, '0);
        while (shadow_count < DEPTH)
        begin
            if ($urandom_range(0, 1) == 1)
                send_request(FUNC_APPEND, 7'($urandom_range(0, 127)), 7'd0, 5'd0,
                             random_entry());
            else
                send_request(FUNC_INSERT, 7'($urandom_range(0, 127)), 7'd0, 5'd0,
                             random_entry());
        end
        send_request(FUNC_APPEND, 7'd0, 7'd0, 5'd0, random_entry());
        send_request(FUNC_INSERT, 7'd0, 7'd0, 5'd0, random_entry());
        send_request(FUNC_INSERT, 7'd127, 7'd0, 5'd0, random_entry());
        send_request(FUNC_REMAP, 7'd0, absent_note(), 5'($urandom_range(1, 16)), '0);
        last = shadow_table[DEPTH - 1];
        chan = (last.src_chan == 5'd0) ? 5'($urandom_range(1, 16)) : last.src_chan;
        send_request(FUNC_REMAP, 7'd0, last.src_note, chan, '0);
        send_request(FUNC_READ, 7'(DEPTH - 1), 7'd0, 5'd0, '0);
        send_request(FUNC_READ, 7'(DEPTH), 7'd0, 5'd0, '0);
        send_request(FUNC_OVERWRITE, 7'(DEPTH - 1), 7'd0, 5'd0, random_entry());
        send_request(FUNC_REMOVE, 7'd0, 7'd0, 5'd0, '0);
        send_request(FUNC_INSERT, 7'd0, 7'd0, 5'd0, random_entry());
        send_request(FUNC_REMOVE, 7'(DEPTH - 1), 7'd0, 5'd0, '0);
    endtask

    // mixed traffic; alternating grow and shrink phases keep the count sweeping its range
    task automatic test_random_traffic(input int unsigned n_requests);
        bit          grow;
        int unsigned pick;
        int unsigned w_add;
        int unsigned w_rem;
        int          k;
        int          top;
        logic [2:0]  f;
        logic [6:0]  idx;
        logic [6:0]  note;
        logic [4:0]  chan;
        grow = 1'b1;
        for (int unsigned n = 0; n < n_requests; n++)
        begin
            if (n % 150 == 149)
                grow = ~grow;
            w_add = grow ? 20 : 4;
            w_rem = grow ? 4 : 24;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                f = FUNC_REMAP;
            else if (pick < 40)
                f = FUNC_READ;
            else if (pick < 48)
                f = FUNC_OVERWRITE;
            else if (pick < 48 + w_add)
                f = FUNC_APPEND;
            else if (pick < 48 + 2 * w_add)
                f = FUNC_INSERT;
            else if (pick < 48 + 2 * w_add + w_rem)
                f = FUNC_REMOVE;
            else if (pick < 98)
                f = FUNC_REMAP;
            else if (pick == 98)
                f = FUNC_CLEAR;
            else
                f = FUNC_UNUSED;

            top = shadow_count - 1 + ((f == FUNC_INSERT) ? 1 : 0);
            if (top >= 0 && $urandom_range(0, 4) != 0)
                idx = 7'($urandom_range(0, top));
            else
                idx = 7'($urandom_range(0, 127));

            note = 7'($urandom_range(0, 127));
            chan = 5'($urandom_range(0, 16));
            if (shadow_count > 0 && $urandom_range(0, 2) != 0)
            begin
                k = $urandom_range(0, shadow_count - 1);
                note = shadow_table[k].src_note;
                if (shadow_table[k].src_chan == 5'd0)
                    chan = 5'($urandom_range(1, 16));
                else
                    chan = shadow_table[k].src_chan;
            end
            send_request(f, idx, note, chan, random_entry());
        end
    endtask

    initial
    begin
        error_count = 0;
        results_checked = 0;
        burst_left = 0;
        shadow_count = 0;
        remap_hits = 0;
        remap_misses = 0;
        full_rejects = 0;
        bad_index_hits = 0;
        foreach (requests_by_func[i])
            requests_by_func[i] = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= FUNC_REMAP;
        index <= 7'd0;
        in_note <= 7'd0;
        in_channel <= 5'd0;
        entry_source_note <= 7'd0;
        entry_source_channel <= 5'd0;
        entry_target_note <= 7'd0;
        entry_target_channel <= 5'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_edit_and_match();
        test_full_table();
        test_random_traffic(RANDOM_REQUESTS);
        test_full_table();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d remaps (%0d hit, %0d miss), %0d reads",
                 results_checked, requests_by_func[FUNC_REMAP], remap_hits, remap_misses,
                 requests_by_func[FUNC_READ]);
        $display("edits: %0d append, %0d insert, %0d remove, %0d clear; %0d full, %0d bad index",
                 requests_by_func[FUNC_APPEND], requests_by_func[FUNC_INSERT],
                 requests_by_func[FUNC_REMOVE], requests_by_func[FUNC_CLEAR], full_rejects,
                 bad_index_hits);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
